### rtl/pksc_pkg.sv
// ----------------------------------------------------------------------------
// pksc_pkg
// Shared types, constants and the quadrature direction table for the panel
// knob and switch scanner.
// ----------------------------------------------------------------------------
package pksc_pkg;

  localparam int unsigned SwW     = 8;
  localparam int unsigned AddrPosW = 3;
  localparam int unsigned DataPosW = 2;
  localparam int unsigned TdataW  = 24;

  localparam logic [SwW-1:0] SwitchInvert = 8'o376;
  localparam logic [SwW-1:0] EventMask    = 8'o236;
  localparam int unsigned    HaltBit      = 5;

  typedef enum logic [1:0] {
    DIR_NONE = 2'd0,
    DIR_CW   = 2'd1,
    DIR_CCW  = 2'd2
  } dir_e;

  // per-transaction control shared by both knob lanes
  typedef struct packed {
    logic accept;
    logic first_scan;
    logic reverse;
  } knob_ctrl_t;

  typedef struct packed {
    logic [SwW-1:0] levels;
    logic [SwW-1:0] events;
    logic           halt;
    logic           power_off;
  } sw_res_t;

  // previous code x current code -> direction
  function automatic dir_e step_dir(input logic [1:0] prev, input logic [1:0] code);
    dir_e d;
    d = DIR_NONE;
    case ({prev, code})
      4'b00_01: d = DIR_CCW;
      4'b00_10: d = DIR_CW;
      4'b01_00: d = DIR_CW;
      4'b01_11: d = DIR_CCW;
      4'b10_00: d = DIR_CCW;
      4'b10_11: d = DIR_CW;
      4'b11_01: d = DIR_CW;
      4'b11_10: d = DIR_CCW;
      default:  d = DIR_NONE;
    endcase
    return d;
  endfunction

endpackage

### rtl/pksc_knob_lane.sv
// ----------------------------------------------------------------------------
// pksc_knob_lane
// One rotary encoder lane: position and sub-step counter updated from the
// previous and current Gray code, with forced position reload.
// ----------------------------------------------------------------------------
module pksc_knob_lane import pksc_pkg::*; #(
  parameter int unsigned POS_W = 3,
  parameter int unsigned STEPS = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  knob_ctrl_t       ctrl_i,
  input  logic [1:0]       code_i,
  input  logic             force_i,
  input  logic [POS_W-1:0] forced_pos_i,
  output logic [POS_W-1:0] pos_o
);

  localparam int unsigned SUB_W = (STEPS > 1) ? $clog2(STEPS) : 1;
  localparam logic [SUB_W-1:0] SUB_MAX = SUB_W'(STEPS - 1);

  // counter kept as position and sub-step so no divide is needed
  logic [POS_W-1:0] pos_q, pos_d;
  logic [SUB_W-1:0] sub_q, sub_d;
  logic [1:0]       prev_q;
  dir_e             dir;
  logic             up;

  always_comb begin
    pos_d = pos_q;
    sub_d = sub_q;
    dir   = step_dir(prev_q, code_i);
    up    = (dir == DIR_CW) ^ ctrl_i.reverse;
    if (ctrl_i.first_scan) begin
      if (force_i) begin
        pos_d = forced_pos_i;
      end
      sub_d = '0;
    end else begin
      if (force_i && (forced_pos_i != pos_q)) begin
        pos_d = forced_pos_i;
        sub_d = '0;
      end
      if (dir != DIR_NONE) begin
        if (up) begin
          if (sub_d == SUB_MAX) begin
            sub_d = '0;
            pos_d = pos_d + POS_W'(1);
          end else begin
            sub_d = sub_d + SUB_W'(1);
          end
        end else begin
          if (sub_d == '0) begin
            sub_d = SUB_MAX;
            pos_d = pos_d - POS_W'(1);
          end else begin
            sub_d = sub_d - SUB_W'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= POS_W'(1);
      sub_q  <= '0;
      prev_q <= 2'b00;
    end else if (ctrl_i.accept) begin
      pos_q  <= pos_d;
      sub_q  <= sub_d;
      prev_q <= code_i;
    end
  end

  assign pos_o = pos_d;

endmodule

### rtl/pksc_switch_unit.sv
// ----------------------------------------------------------------------------
// pksc_switch_unit
// Action switch levels, rising-edge event latch and power-off latch; merges
// into the halt request.
// ----------------------------------------------------------------------------
module pksc_switch_unit import pksc_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           accept_i,
  input  logic [SwW-1:0] raw_i,
  input  logic           power_raw_i,
  input  logic           clear_i,
  output sw_res_t        res_o
);

  logic [SwW-1:0] prev_q, events_q, events_d, levels;
  logic           power_q, power_d;

  always_comb begin
    levels   = raw_i ^ SwitchInvert;
    events_d = (clear_i ? '0 : events_q) | (levels & ~prev_q & EventMask);
    power_d  = power_q | ~power_raw_i;
    res_o.levels    = levels;
    res_o.events    = events_d;
    res_o.power_off = power_d;
    res_o.halt      = power_d | levels[HaltBit];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q   <= '0;
      events_q <= '0;
      power_q  <= 1'b0;
    end else if (accept_i) begin
      prev_q   <= levels;
      events_q <= events_d;
      power_q  <= power_d;
    end
  end

endmodule

### rtl/panel_knob_and_switch_scanner_unit.sv
// result: an accepted scan's result appears in the output register in the next cycle
// throughput: one scan per cycle; tready is low only while a held result is not taken
// the two knob lanes and the switch unit each update from registered state on an accepted scan
// reset: async active low; knobs at position 1, codes, events and power latch cleared
// ----------------------------------------------------------------------------
// panel_knob_and_switch_scanner_unit
// Front-panel scan decoder: two quadrature knob lanes and a switch/event
// unit in parallel, merged into one registered result transaction.
// ----------------------------------------------------------------------------
module panel_knob_and_switch_scanner_unit import pksc_pkg::*; #(
  parameter int unsigned STEPS_PER_DETENT = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_wdata_i,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  // [11:0] scan_bits, [12] power_raw, [13] clear_events, [14] set_addr_knob,
  // [17:15] addr_knob_value, [18] set_data_knob, [20:19] data_knob_value, [23:21] zero
  input  logic [TdataW-1:0] s_axis_tdata,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  // [2:0] addr_knob, [4:3] data_knob, [12:5] switch_levels, [20:13] pending_events,
  // [21] halt_request, [22] power_off, [23] zero
  output logic [TdataW-1:0] m_axis_tdata
);

  logic                reverse_q;
  logic                first_scan_q;
  logic                out_valid_q;
  logic [TdataW-1:0]   out_q;
  logic                in_acc;
  knob_ctrl_t          ctrl;
  logic [AddrPosW-1:0] addr_pos;
  logic [DataPosW-1:0] data_pos;
  sw_res_t             sw_res;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  assign ctrl.accept     = in_acc;
  assign ctrl.first_scan = first_scan_q;
  assign ctrl.reverse    = reverse_q;

  pksc_knob_lane #(
    .POS_W (AddrPosW),
    .STEPS (STEPS_PER_DETENT)
  ) u_addr_lane (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (ctrl),
    .code_i       (s_axis_tdata[9:8]),
    .force_i      (s_axis_tdata[14]),
    .forced_pos_i (s_axis_tdata[17:15]),
    .pos_o        (addr_pos)
  );

  pksc_knob_lane #(
    .POS_W (DataPosW),
    .STEPS (STEPS_PER_DETENT)
  ) u_data_lane (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (ctrl),
    .code_i       (s_axis_tdata[11:10]),
    .force_i      (s_axis_tdata[18]),
    .forced_pos_i (s_axis_tdata[20:19]),
    .pos_o        (data_pos)
  );

  pksc_switch_unit u_switch (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (in_acc),
    .raw_i       (s_axis_tdata[7:0]),
    .power_raw_i (s_axis_tdata[12]),
    .clear_i     (s_axis_tdata[13]),
    .res_o       (sw_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reverse_q    <= 1'b0;
      first_scan_q <= 1'b1;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        reverse_q <= cfg_wdata_i;
      end
      if (in_acc) begin
        first_scan_q <= 1'b0;
        out_valid_q  <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // merge lanes into the result register
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      out_q <= {1'b0, sw_res.power_off, sw_res.halt, sw_res.events, sw_res.levels,
                data_pos, addr_pos};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

`ifndef SYNTHESIS
  a_acc_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> out_valid_q)
    else $error("accepted scan did not produce a result");

  a_first_scan_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !first_scan_q |=> !first_scan_q)
    else $error("first scan flag came back");

  a_first_until_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (first_scan_q && !in_acc) |=> first_scan_q)
    else $error("first scan flag cleared without a transaction");

  a_power_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q[22] && in_acc) |=> out_q[22])
    else $error("power off latch dropped");

  a_power_halts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q[22]) |-> out_q[21])
    else $error("power off without halt request");
`endif

endmodule
